[hw/rtl/rgbcf_pkg.sv]
// Package for the RGB color crossfade block.
// Holds the controller states, the command and status structs and shared constants.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rgbcf_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned DUR_W   = 16;
	localparam int unsigned COLOR_W = 24;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned NUM_W   = DUR_W + CHAN_W;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [DUR_W-1:0]   DUR_RESET     = 16'd1000;
	localparam logic [COLOR_W-1:0] COLOR_A_RESET = 24'h00FFFF;
	localparam logic [COLOR_W-1:0] COLOR_B_RESET = 24'hFF00FF;
	localparam logic [COLOR_W-1:0] COLOR_C_RESET = 24'hFFFF00;

	localparam logic [CFG_IDX_W-1:0] REG_FADE_DURATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_A       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_B       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_C       = 2'd3;

	localparam logic [1:0] SEQ_A = 2'd0;
	localparam logic [1:0] SEQ_B = 2'd1;
	localparam logic [1:0] SEQ_C = 2'd2;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_CALC,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load_in;
		logic       init;
		logic       calc;
		logic       mul;
		logic       div_step;
		logic       div_last;
		logic       emit;
		logic [1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	function automatic logic [1:0] seq_next(input logic [1:0] idx);
		seq_next = (idx >= SEQ_C) ? SEQ_A : idx + 2'd1;
	endfunction

	function automatic logic [CHAN_W-1:0] chan_byte(input logic [COLOR_W-1:0] color,
		input logic [1:0] ch);
		unique case (ch)
			CH_RED:   chan_byte = color[23:16];
			CH_GREEN: chan_byte = color[15:8];
			default:  chan_byte = color[7:0];
		endcase
	endfunction

endpackage

`default_nettype wire

[hw/rtl/rgbcf_ctrl.sv]
// Controller of the RGB color crossfade block.
// Sequences setup, per-channel multiply and bit-serial divide, and result hand-off.
// Depends on rgbcf_pkg.
`default_nettype none

module rgbcf_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  rgbcf_pkg::status_t status,
	output rgbcf_pkg::cmd_t    cmd
);
	import rgbcf_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] ch_q, ch_d;
	logic [2:0] bit_q, bit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= CH_RED;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			bit_q   <= bit_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ch_d     = ch_q;
		bit_d    = bit_q;
		cmd      = '0;
		cmd.ch   = ch_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				ch_d     = CH_RED;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				bit_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				bit_d        = bit_q + 3'd1;
				if (bit_q == LAST_BIT) begin
					cmd.div_last = 1'b1;
					if (ch_q == CH_BLUE) begin
						state_d = ST_EMIT;
					end else begin
						ch_d    = ch_q + 2'd1;
						state_d = ST_MUL;
					end
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/rgbcf_dp.sv]
// Datapath of the RGB color crossfade block.
// Holds configuration, fade state, the channel multiplier, a restoring divider and
// the output register. Depends on rgbcf_pkg.
`default_nettype none

module rgbcf_dp (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wr_en,
	input  wire  [rgbcf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [rgbcf_pkg::COLOR_W-1:0]        cfg_data,
	input  wire  [rgbcf_pkg::TIME_W-1:0]         now_time,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [rgbcf_pkg::CHAN_W-1:0]         red,
	output logic [rgbcf_pkg::CHAN_W-1:0]         green,
	output logic [rgbcf_pkg::CHAN_W-1:0]         blue,
	output logic                                 fade_done,
	input  rgbcf_pkg::cmd_t                      cmd,
	output rgbcf_pkg::status_t                   status
);
	import rgbcf_pkg::*;

	logic [DUR_W-1:0]   dur_q;
	logic [COLOR_W-1:0] color_a_q, color_b_q, color_c_q;

	logic               started_q;
	logic [1:0]         seq_q;
	logic [COLOR_W-1:0] from_q, to_q;
	logic [TIME_W-1:0]  start_q;

	logic [TIME_W-1:0]  now_q;
	logic [DUR_W-1:0]   e_q;
	logic               done_q;
	logic [DUR_W-1:0]   rem_q;
	logic [CHAN_W-1:0]  low_q;
	logic [CHAN_W-1:0]  quo_q;
	logic [CHAN_W-1:0]  red_q, green_q, blue_q;

	logic [DUR_W-1:0]   d_eff;
	logic [TIME_W-1:0]  elapsed;
	logic               reached;
	logic [NUM_W-1:0]   num;
	logic [DUR_W:0]     trial;
	logic               ge;
	logic [CHAN_W-1:0]  quo_next;
	logic [1:0]         seq_adv;

	function automatic logic [COLOR_W-1:0] seq_color(input logic [1:0] idx,
		input logic [COLOR_W-1:0] ca, input logic [COLOR_W-1:0] cb,
		input logic [COLOR_W-1:0] cc);
		unique case (idx)
			SEQ_A:   seq_color = ca;
			SEQ_B:   seq_color = cb;
			default: seq_color = cc;
		endcase
	endfunction

	assign d_eff   = (dur_q == '0) ? DUR_W'(1) : dur_q;
	assign elapsed = now_q - start_q;
	assign reached = elapsed >= TIME_W'(d_eff);
	assign num     = NUM_W'(chan_byte(from_q, cmd.ch) * (d_eff - e_q))
	               + NUM_W'(chan_byte(to_q, cmd.ch) * e_q);
	assign trial    = {rem_q, low_q[CHAN_W-1]};
	assign ge       = trial >= {1'b0, d_eff};
	assign quo_next = {quo_q[CHAN_W-2:0], ge};
	assign seq_adv  = seq_next(seq_q);
	assign status.out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q     <= DUR_RESET;
			color_a_q <= COLOR_A_RESET;
			color_b_q <= COLOR_B_RESET;
			color_c_q <= COLOR_C_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FADE_DURATION: dur_q     <= cfg_data[DUR_W-1:0];
				REG_COLOR_A:       color_a_q <= cfg_data;
				REG_COLOR_B:       color_b_q <= cfg_data;
				default:           color_c_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			seq_q     <= SEQ_A;
			from_q    <= '0;
			to_q      <= '0;
			start_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.init && !started_q) begin
				started_q <= 1'b1;
				from_q    <= seq_color(seq_q, color_a_q, color_b_q, color_c_q);
				to_q      <= seq_color(seq_adv, color_a_q, color_b_q, color_c_q);
				start_q   <= now_q;
			end
			if (cmd.emit && done_q) begin
				seq_q   <= seq_adv;
				from_q  <= to_q;
				to_q    <= seq_color(seq_next(seq_adv), color_a_q, color_b_q, color_c_q);
				start_q <= now_q;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_q <= now_time;
		end
		if (cmd.calc) begin
			done_q <= reached;
			e_q    <= reached ? d_eff : elapsed[DUR_W-1:0];
		end
		if (cmd.mul) begin
			rem_q <= num[NUM_W-1:CHAN_W];
			low_q <= num[CHAN_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? DUR_W'(trial - {1'b0, d_eff}) : trial[DUR_W-1:0];
			low_q <= {low_q[CHAN_W-2:0], 1'b0};
			quo_q <= quo_next;
		end
		if (cmd.div_last) begin
			case (cmd.ch)
				CH_RED:   red_q   <= quo_next;
				CH_GREEN: green_q <= quo_next;
				default:  blue_q  <= quo_next;
			endcase
		end
		if (cmd.emit) begin
			red       <= red_q;
			green     <= green_q;
			blue      <= blue_q;
			fade_done <= done_q;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/rgb_color_crossfade.sv]
// Top level of the RGB color crossfade block.
// Joins the controller and the datapath. Depends on rgbcf_pkg, rgbcf_ctrl, rgbcf_dp.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    now_time
//   output    out        out_valid / out_stall  red, green, blue, fade_done
//   config    in         cfg_wr_en              cfg_index, cfg_data
//
// One item passes from acceptance to its result through setup, elapsed time, then
// per channel one multiply step and eight steps of the shared restoring divider.
// The next item is accepted the cycle after the result enters the output register,
// so the block takes no new item while one is in work.
// Reset clears the fade state and loads the default duration and colors.
// A stalled result holds the output register; the controller waits before handing over
// the next one.
`default_nettype none

module rgb_color_crossfade (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wr_en,
	input  wire  [rgbcf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [rgbcf_pkg::COLOR_W-1:0]        cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire  [rgbcf_pkg::TIME_W-1:0]         now_time,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [rgbcf_pkg::CHAN_W-1:0]         red,
	output logic [rgbcf_pkg::CHAN_W-1:0]         green,
	output logic [rgbcf_pkg::CHAN_W-1:0]         blue,
	output logic                                 fade_done
);
	import rgbcf_pkg::*;

	cmd_t    cmd;
	status_t status;

	rgbcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rgbcf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.now_time  (now_time),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.fade_done (fade_done),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

`default_nettype wire

[hw/rtl/rgbcf_chk.sv]
// Port-level checker for the RGB color crossfade block, bound to the top level.
// Depends on rgbcf_pkg.
`default_nettype none

module rgbcf_chk (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             in_valid,
	input wire                             in_stall,
	input wire                             out_valid,
	input wire                             out_stall,
	input wire [rgbcf_pkg::CHAN_W-1:0]     red,
	input wire [rgbcf_pkg::CHAN_W-1:0]     green,
	input wire [rgbcf_pkg::CHAN_W-1:0]     blue,
	input wire                             fade_done
);
	import rgbcf_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue) && $stable(fade_done))
		else $error("stalled result changed");

	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("item accepted while previous item in work");

	a_busy_later: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> ##8 in_stall)
		else $error("block idle too early after accepting an item");

endmodule

bind rgb_color_crossfade rgbcf_chk u_chk (.*);

`default_nettype wire
